@@ hw/rtl/asd_pkg.sv @@
`timescale 1ns / 1ps

package asd_pkg;

  // Raw axis sample and centred axis widths.
  localparam int RawW    = 12;
  localparam int ByteW   = 8;
  localparam int AxisXW  = 12;
  localparam int AxisYZW = 13;

  // Squares, magnitude, adaptive limit and step count.
  localparam int SqW    = 23;
  localparam int MagW   = 24;
  localparam int LimitW = 25;
  localparam int CountW = 16;

  // Calibration register.
  localparam int ZOffW = 9;

  localparam logic signed [AxisYZW-1:0] CenterValue  = 13'sh800;
  localparam logic signed [ZOffW-1:0]   ZOffsetReset = 9'sd128;

  // Request from the datapath to the step detector.
  typedef struct packed {
    logic            update;
    logic [MagW-1:0] magnitude_sq;
  } det_req_t;

  // Result of the step detector for one sample.
  typedef struct packed {
    logic              step_event;
    logic [CountW-1:0] step_total;
  } step_res_t;

  // Builds the 12-bit raw sample from the high byte and the upper nibble of the low byte.
  function automatic logic [RawW-1:0] raw12(input logic [ByteW-1:0] hi,
                                            input logic [ByteW-1:0] lo);
    raw12 = {hi, lo[ByteW-1:ByteW-4]};
  endfunction

endpackage

@@ hw/rtl/asd_if.sv @@
`timescale 1ns / 1ps

interface asd_sample_if;
  logic                      valid;
  logic                      ready;
  logic [asd_pkg::ByteW-1:0] x_high;
  logic [asd_pkg::ByteW-1:0] x_low;
  logic [asd_pkg::ByteW-1:0] y_high;
  logic [asd_pkg::ByteW-1:0] y_low;
  logic [asd_pkg::ByteW-1:0] z_high;
  logic [asd_pkg::ByteW-1:0] z_low;

  modport source (output valid, x_high, x_low, y_high, y_low, z_high, z_low, input ready);
  modport sink   (input valid, x_high, x_low, y_high, y_low, z_high, z_low, output ready);
endinterface

interface asd_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [asd_pkg::AxisXW-1:0]  accel_x;
  logic signed [asd_pkg::AxisYZW-1:0] accel_y;
  logic signed [asd_pkg::AxisYZW-1:0] accel_z;
  logic [asd_pkg::MagW-1:0]           magnitude_sq;
  logic                               step_event;
  logic [asd_pkg::CountW-1:0]         step_total;

  modport source (output valid, accel_x, accel_y, accel_z, magnitude_sq, step_event,
                  step_total, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, magnitude_sq, step_event,
                  step_total, output ready);
endinterface

@@ hw/rtl/asd_step_det.sv @@
`timescale 1ns / 1ps

module asd_step_det (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asd_pkg::det_req_t req_i,
  output asd_pkg::step_res_t res_o
);

  logic                       phase_up_q, phase_up_d;
  logic [asd_pkg::LimitW-1:0] limit_q, limit_d;
  logic [asd_pkg::CountW-1:0] count_q, count_d;
  logic [asd_pkg::LimitW-1:0] mag_w, half_w, twice_w;
  logic                       event_w;

  assign mag_w   = {1'b0, req_i.magnitude_sq};
  assign half_w  = {2'b00, req_i.magnitude_sq[asd_pkg::MagW-1:1]};
  assign twice_w = {req_i.magnitude_sq, 1'b0};

  always_comb begin
    phase_up_d = phase_up_q;
    limit_d    = limit_q;
    count_d    = count_q;
    event_w    = 1'b0;
    if (phase_up_q) begin
      if (mag_w > limit_q) begin
        // Peak passed: count it and wait for the next trough.
        phase_up_d = 1'b0;
        limit_d    = half_w;
        count_d    = count_q + 1'b1;
        event_w    = 1'b1;
      end else if (limit_q > twice_w) begin
        limit_d = twice_w;
      end
    end else begin
      if (mag_w < limit_q) begin
        phase_up_d = 1'b1;
        limit_d    = twice_w;
      end else if (limit_q < half_w) begin
        limit_d = half_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_up_q <= 1'b0;
      limit_q    <= '0;
      count_q    <= '0;
    end else if (req_i.update) begin
      phase_up_q <= phase_up_d;
      limit_q    <= limit_d;
      count_q    <= count_d;
    end
  end

  assign res_o.step_event = event_w;
  assign res_o.step_total = count_d;

endmodule

@@ hw/rtl/accel_sample_step_detector.sv @@
`timescale 1ns / 1ps

// Accelerometer sample decoder and step counter. Each transfer on sample_i carries one
// six-byte readout; the block centres the three axes (z with the calibration offset held in
// the register written through cfg_we_i / cfg_data_i, 128 after reset), forms the squared
// magnitude and runs a two-phase peak/trough step detector, giving exactly one transfer on
// result_o per sample. The datapath is a four-register pipeline (centred axes, squares,
// magnitude, result register). The edge that takes a sample loads the first of these, and the
// sample then moves on through the others in that order. A new sample is accepted every cycle as
// long as the result register is empty or being taken in the same cycle; the whole pipeline
// holds while result_o is stalled.
// The step counter wraps at 65536 and is cleared only by reset. Write the offset only
// while no samples are in flight.
module accel_sample_step_detector (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [asd_pkg::ZOffW-1:0] cfg_data_i,
  asd_sample_if.sink                sample_i,
  asd_result_if.source              result_o
);

  // Pipeline control: every stage moves together when the result register can take data.
  logic advance;

  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q;

  // Calibration offset for the z axis.
  logic signed [asd_pkg::ZOffW-1:0] z_offset_q;

  // Stage A: centred axes.
  logic [asd_pkg::RawW-1:0]             raw_x_w, raw_y_w, raw_z_w;
  logic signed [asd_pkg::AxisXW-1:0]    ax_d, ax_a_q;
  logic signed [asd_pkg::AxisYZW-1:0]   ay_d, az_d, ay_a_q, az_a_q;

  // Stage B: squares, axes carried along.
  logic signed [2*asd_pkg::AxisXW-1:0]  sqx_w;
  logic signed [2*asd_pkg::AxisYZW-1:0] sqy_w, sqz_w;
  logic [asd_pkg::SqW-1:0]              sqx_q, sqy_q, sqz_q;
  logic signed [asd_pkg::AxisXW-1:0]    ax_b_q;
  logic signed [asd_pkg::AxisYZW-1:0]   ay_b_q, az_b_q;

  // Stage C: magnitude, axes carried along.
  logic [asd_pkg::MagW-1:0]             mag_d, mag_c_q;
  logic signed [asd_pkg::AxisXW-1:0]    ax_c_q;
  logic signed [asd_pkg::AxisYZW-1:0]   ay_c_q, az_c_q;

  // Stage D: result register.
  logic signed [asd_pkg::AxisXW-1:0]    ax_d_q;
  logic signed [asd_pkg::AxisYZW-1:0]   ay_d_q, az_d_q;
  logic [asd_pkg::MagW-1:0]             mag_d_q;
  asd_pkg::step_res_t                   step_res_w, step_res_q;
  asd_pkg::det_req_t                    det_req_w;

  assign advance        = !d_valid_q || result_o.ready;
  assign sample_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_offset_q <= asd_pkg::ZOffsetReset;
    end else if (cfg_we_i) begin
      z_offset_q <= cfg_data_i;
    end
  end

  // Centring. The x axis is the raw value with its top bit inverted; y and z are negated
  // about the centre, z then shifted by the sign-extended calibration offset.
  assign raw_x_w = asd_pkg::raw12(sample_i.x_high, sample_i.x_low);
  assign raw_y_w = asd_pkg::raw12(sample_i.y_high, sample_i.y_low);
  assign raw_z_w = asd_pkg::raw12(sample_i.z_high, sample_i.z_low);

  assign ax_d = $signed({~raw_x_w[asd_pkg::RawW-1], raw_x_w[asd_pkg::RawW-2:0]});
  assign ay_d = asd_pkg::CenterValue - $signed({1'b0, raw_y_w});
  assign az_d = asd_pkg::CenterValue - $signed({1'b0, raw_z_w})
              + $signed({{(asd_pkg::AxisYZW - asd_pkg::ZOffW){z_offset_q[asd_pkg::ZOffW-1]}},
                         z_offset_q});

  // Squares are never negative and stay below 2^23, so the low bits carry them whole.
  assign sqx_w = ax_a_q * ax_a_q;
  assign sqy_w = ay_a_q * ay_a_q;
  assign sqz_w = az_a_q * az_a_q;

  assign mag_d = asd_pkg::MagW'(sqx_q) + asd_pkg::MagW'(sqy_q) + asd_pkg::MagW'(sqz_q);

  // The detector state advances once per sample, as the sample enters the result register.
  assign det_req_w.update       = advance && c_valid_q;
  assign det_req_w.magnitude_sq = mag_c_q;

  asd_step_det u_step_det (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (det_req_w),
    .res_o  (step_res_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= sample_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ax_a_q     <= ax_d;
      ay_a_q     <= ay_d;
      az_a_q     <= az_d;
      sqx_q      <= sqx_w[asd_pkg::SqW-1:0];
      sqy_q      <= sqy_w[asd_pkg::SqW-1:0];
      sqz_q      <= sqz_w[asd_pkg::SqW-1:0];
      ax_b_q     <= ax_a_q;
      ay_b_q     <= ay_a_q;
      az_b_q     <= az_a_q;
      mag_c_q    <= mag_d;
      ax_c_q     <= ax_b_q;
      ay_c_q     <= ay_b_q;
      az_c_q     <= az_b_q;
      mag_d_q    <= mag_c_q;
      ax_d_q     <= ax_c_q;
      ay_d_q     <= ay_c_q;
      az_d_q     <= az_c_q;
      step_res_q <= step_res_w;
    end
  end

  assign result_o.valid        = d_valid_q;
  assign result_o.accel_x      = ax_d_q;
  assign result_o.accel_y      = ay_d_q;
  assign result_o.accel_z      = az_d_q;
  assign result_o.magnitude_sq = mag_d_q;
  assign result_o.step_event   = step_res_q.step_event;
  assign result_o.step_total   = step_res_q.step_total;

`ifndef SYNTHESIS
  logic signed [2*asd_pkg::AxisXW-1:0]  chk_x;
  logic signed [2*asd_pkg::AxisYZW-1:0] chk_y, chk_z;
  logic [asd_pkg::MagW-1:0]             chk_mag;

  assign chk_x   = result_o.accel_x * result_o.accel_x;
  assign chk_y   = result_o.accel_y * result_o.accel_y;
  assign chk_z   = result_o.accel_z * result_o.accel_z;
  assign chk_mag = chk_x[asd_pkg::MagW-1:0] + chk_y[asd_pkg::MagW-1:0]
                 + chk_z[asd_pkg::MagW-1:0];

  // The magnitude must belong to the axes it travels with through the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.magnitude_sq == chk_mag)
    else $error("magnitude out of step with its axes");

  // A step needs a magnitude above a limit that is never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.step_event |-> result_o.magnitude_sq != '0)
    else $error("step counted on a zero magnitude");

  // The step total moves by one exactly when a step is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.ready ##1 result_o.valid && $past(advance)
      && $changed(step_res_q) |-> result_o.step_total
      == $past(result_o.step_total) + (result_o.step_event ? 16'd1 : 16'd0))
    else $error("step total does not follow the step events");
`endif

endmodule
